// File: rtl/skts_pkg.sv
package skts_pkg;

    // Width of one table entry and of a search key.
    localparam int DATA_W = 32;

    // Default table depth.
    localparam int TABLE_DEPTH_DEF = 1024;

    // Widths of the fixed port fields.
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int MODE_W  = 2;

    // Search modes. The unused code searches as binary.
    localparam logic [MODE_W-1:0] MODE_BINARY     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TERNARY    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUATERNARY = 2'd2;

    // Command codes.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Configuration register indexes.
    localparam logic REG_SEARCH_MODE = 1'b0;
    localparam logic REG_ENTRY_COUNT = 1'b1;

    // Outcome of comparing the key against one table entry.
    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_res_t;

endpackage

// File: rtl/skts_ram.sv
module skts_ram #(
    parameter int DEPTH = skts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(DEPTH)-1:0]          waddr,
    input  logic signed [skts_pkg::DATA_W-1:0] wdata,
    input  logic                              re,
    input  logic [$clog2(DEPTH)-1:0]          raddr,
    output logic signed [skts_pkg::DATA_W-1:0] rdata
);
    import skts_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/skts_cmp.sv
module skts_cmp (
    input  logic signed [skts_pkg::DATA_W-1:0] key,
    input  logic signed [skts_pkg::DATA_W-1:0] entry,
    output skts_pkg::cmp_res_t                 res
);
    import skts_pkg::*;

    // Signed compare of the key against the probed entry.
    always_comb
    begin
        res.eq = (key == entry);
        res.lt = (key < entry);
    end

endmodule

// File: rtl/kary_sorted_table_search.sv
// Sorted table with a k-ary search. A word on the command channel is taken
// when start is high and busy is low. A write word (cmd = 0) stores
// entry_value at entry_index modulo TABLE_DEPTH and gives no result; the
// index is reduced by one subtraction of TABLE_DEPTH for each time the depth
// fits into entry_index (none when TABLE_DEPTH is 1024 or more). A search word
// (cmd = 1) gives exactly one result word: done is high for a single cycle
// with found and position, and the receiver cannot stall it, so it must
// take the word in that cycle. A search over the interval [0, n-1], with n
// the entry count saturated to TABLE_DEPTH, runs level by level; each level
// passes ST_SPAN, ST_MUL and ST_PROBE, then ST_ISSUE and ST_CHECK for each
// of its k probes (1 binary, 2 ternary, 3 quaternary), because every probe
// reads the one table port and then goes through the one shared comparator.
// A binary search of 1024 entries takes about 11 levels; a hit ends the
// search at the probe that matches. The table is not cleared by reset: an
// entry must be written before a search may read it. The configuration
// port is always ready and must only be written while busy is low.
module kary_sorted_table_search #(
    parameter int TABLE_DEPTH = skts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [skts_pkg::COUNT_W-1:0]        cfg_data,
    // Command channel.
    input  logic                                start,
    output logic                                busy,
    input  logic                                cmd,
    input  logic [skts_pkg::INDEX_W-1:0]        entry_index,
    input  logic signed [skts_pkg::DATA_W-1:0]  entry_value,
    input  logic signed [skts_pkg::DATA_W-1:0]  search_key,
    // Result strobe and payload.
    output logic                                done,
    output logic                                found,
    output logic [skts_pkg::INDEX_W-1:0]        position
);
    import skts_pkg::*;

    // Address width of the table, and the width of a span within it.
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int SW  = AW;
    // Interval bounds are signed so that hi can drop to -1 and lo can pass
    // the last entry.
    localparam int PW  = AW + 2;
    // Width used to compare counts and indexes against the depth.
    localparam int CW  = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
    // span / 3 is a multiply by ceil(2^RK / 3) and a shift by RK; exact for
    // every span below 2^SW.
    localparam int RK  = SW + 1;
    localparam int PRW = SW + RK;
    localparam logic [RK-1:0] RECIP3 = RK'((2 ** RK + 2) / 3);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_SPAN,
        ST_MUL,
        ST_PROBE,
        ST_ISSUE,
        ST_CHECK
    } state_t;

    state_t                   state_reg,  state_next;
    logic [MODE_W-1:0]        mode_reg,   mode_next;
    logic [COUNT_W-1:0]       count_reg,  count_next;
    logic signed [DATA_W-1:0] key_reg,    key_next;
    logic signed [DATA_W-1:0] wval_reg,   wval_next;
    logic [INDEX_W-1:0]       widx_reg,   widx_next;
    logic signed [PW-1:0]     lo_reg,     lo_next;
    logic signed [PW-1:0]     hi_reg,     hi_next;
    logic [SW-1:0]            span_reg,   span_next;
    logic [PRW-1:0]           prod_reg,   prod_next;
    logic signed [PW-1:0]     p_reg [3];
    logic signed [PW-1:0]     p_next [3];
    logic [1:0]               k_reg,      k_next;
    logic [2:0]               lt_reg,     lt_next;
    logic                     done_reg,   done_next;
    logic                     found_reg,  found_next;
    logic [INDEX_W-1:0]       pos_reg,    pos_next;

    // Datapath helpers.
    logic [CW-1:0]            widx_ext;
    logic                     wrap_over;
    logic [CW-1:0]            count_ext;
    logic [CW-1:0]            n_sat;
    logic signed [PW-1:0]     span_diff;
    logic [SW-1:0]            half;
    logic [SW-1:0]            quarter;
    logic [SW+1:0]            three_span;
    logic [SW-1:0]            three_quarter;
    logic [SW-1:0]            third;
    logic signed [PW-1:0]     half_s;
    logic signed [PW-1:0]     quarter_s;
    logic signed [PW-1:0]     three_s;
    logic signed [PW-1:0]     third_s;
    logic signed [PW-1:0]     probe_cur;
    logic [PW+INDEX_W-1:0]    pos_wide;
    logic [1:0]               last_k;
    logic [2:0]               lt_cur;

    // Table and comparator connections.
    logic                     ram_we;
    logic                     ram_re;
    logic [AW-1:0]            ram_raddr;
    logic signed [DATA_W-1:0] ram_rdata;
    cmp_res_t                 cmp_res;

    // A write index past the depth is brought in range by repeated
    // subtraction of the depth.
    assign widx_ext  = CW'(widx_reg);
    assign wrap_over = (widx_ext >= DEPTH_C);

    // Entry count saturates to the depth.
    assign count_ext = CW'(count_reg);
    assign n_sat     = (count_ext > DEPTH_C) ? DEPTH_C : count_ext;

    // Split points of the current span. The span is never negative here.
    assign span_diff     = hi_reg - lo_reg;
    assign half          = span_reg >> 1;
    assign quarter       = span_reg >> 2;
    assign three_span    = {2'b00, span_reg} + {1'b0, span_reg, 1'b0};
    assign three_quarter = three_span[SW+1:2];
    assign third         = prod_reg[PRW-1:RK];
    assign half_s        = $signed({2'b00, half});
    assign quarter_s     = $signed({2'b00, quarter});
    assign three_s       = $signed({2'b00, three_quarter});
    assign third_s       = $signed({2'b00, third});

    // The probe being read; it always lies inside [0, n-1].
    assign probe_cur = p_reg[k_reg];
    assign pos_wide  = {{INDEX_W{1'b0}}, probe_cur};
    assign ram_raddr = probe_cur[AW-1:0];

    assign ram_we = (state_reg == ST_WRAP) && !wrap_over;
    assign ram_re = (state_reg == ST_ISSUE);

    // Index of the last probe of a level for the current mode.
    always_comb
    begin
        case (mode_reg)
            MODE_TERNARY:    last_k = 2'd1;
            MODE_QUATERNARY: last_k = 2'd2;
            default:         last_k = 2'd0;
        endcase
    end

    // Less-than flags of this level, including the probe now compared.
    always_comb
    begin
        lt_cur         = lt_reg;
        lt_cur[k_reg]  = cmp_res.lt;
    end

    skts_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx_ext[AW-1:0]),
        .wdata (wval_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    skts_cmp u_cmp (
        .key   (key_reg),
        .entry (ram_rdata),
        .res   (cmp_res)
    );

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        count_next = count_reg;
        key_next   = key_reg;
        wval_next  = wval_reg;
        widx_next  = widx_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        span_next  = span_reg;
        prod_next  = prod_reg;
        p_next     = p_reg;
        k_next     = k_reg;
        lt_next    = lt_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        pos_next   = pos_reg;

        // Configuration must only be written while idle; the block does not enforce this.
        if (cfg_valid)
        begin
            if (cfg_index == REG_SEARCH_MODE)
            begin
                mode_next = cfg_data[MODE_W-1:0];
            end
            else
            begin
                count_next = cfg_data;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_WRITE)
                    begin
                        widx_next  = entry_index;
                        wval_next  = entry_value;
                        state_next = ST_WRAP;
                    end
                    else
                    begin
                        key_next   = search_key;
                        lo_next    = '0;
                        hi_next    = $signed(PW'(n_sat)) - $signed(PW'(1));
                        state_next = ST_SPAN;
                    end
                end
            end

            ST_WRAP:
            begin
                if (wrap_over)
                begin
                    widx_next = widx_reg - DEPTH_C[INDEX_W-1:0];
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SPAN:
            begin
                if (lo_reg > hi_reg)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b0;
                    pos_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    span_next  = span_diff[SW-1:0];
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                prod_next  = PRW'(span_reg) * PRW'(RECIP3);
                state_next = ST_PROBE;
            end

            ST_PROBE:
            begin
                case (mode_reg)
                    MODE_TERNARY:
                    begin
                        p_next[0] = lo_reg + third_s;
                        p_next[1] = hi_reg - third_s;
                    end
                    MODE_QUATERNARY:
                    begin
                        p_next[0] = lo_reg + quarter_s;
                        p_next[1] = lo_reg + half_s;
                        p_next[2] = lo_reg + three_s;
                    end
                    default:
                    begin
                        p_next[0] = lo_reg + half_s;
                    end
                endcase
                k_next     = 2'd0;
                state_next = ST_ISSUE;
            end

            ST_ISSUE:
            begin
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (cmp_res.eq)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    pos_next   = pos_wide[INDEX_W-1:0];
                    state_next = ST_IDLE;
                end
                else if (k_reg != last_k)
                begin
                    lt_next    = lt_cur;
                    k_next     = k_reg + 2'd1;
                    state_next = ST_ISSUE;
                end
                else
                begin
                    // No probe matched: keep the part where the key can lie.
                    lt_next = lt_cur;
                    case (mode_reg)
                        MODE_TERNARY:
                        begin
                            if (lt_cur[0])
                            begin
                                hi_next = p_reg[0] - $signed(PW'(1));
                            end
                            else if (!lt_cur[1])
                            begin
                                lo_next = p_reg[1] + $signed(PW'(1));
                            end
                            else
                            begin
                                lo_next = p_reg[0] + $signed(PW'(1));
                                hi_next = p_reg[1] - $signed(PW'(1));
                            end
                        end
                        MODE_QUATERNARY:
                        begin
                            if (lt_cur[0])
                            begin
                                hi_next = p_reg[0] - $signed(PW'(1));
                            end
                            else if (lt_cur[1])
                            begin
                                lo_next = p_reg[0] + $signed(PW'(1));
                                hi_next = p_reg[1] - $signed(PW'(1));
                            end
                            else if (lt_cur[2])
                            begin
                                lo_next = p_reg[1] + $signed(PW'(1));
                                hi_next = p_reg[2] - $signed(PW'(1));
                            end
                            else
                            begin
                                lo_next = p_reg[2] + $signed(PW'(1));
                            end
                        end
                        default:
                        begin
                            if (lt_cur[0])
                            begin
                                hi_next = p_reg[0] - $signed(PW'(1));
                            end
                            else
                            begin
                                lo_next = p_reg[0] + $signed(PW'(1));
                            end
                        end
                    endcase
                    state_next = ST_SPAN;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_BINARY;
            count_reg <= '0;
            key_reg   <= '0;
            wval_reg  <= '0;
            widx_reg  <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            span_reg  <= '0;
            prod_reg  <= '0;
            p_reg     <= '{default: '0};
            k_reg     <= '0;
            lt_reg    <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            count_reg <= count_next;
            key_reg   <= key_next;
            wval_reg  <= wval_next;
            widx_reg  <= widx_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            span_reg  <= span_next;
            prod_reg  <= prod_next;
            p_reg     <= p_next;
            k_reg     <= k_next;
            lt_reg    <= lt_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            pos_reg   <= pos_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign found     = found_reg;
    assign position  = pos_reg;

    // A taken command word always makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    // A result word only comes out of a running search.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a search in progress");

    // A miss reports position zero.
    a_miss_position: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (position == '0))
        else $error("miss with a nonzero position");

    // The probe counter never passes the last probe of the mode.
    a_probe_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ISSUE) || (state_reg == ST_CHECK)) |-> (k_reg <= last_k))
        else $error("probe counter beyond the last probe");

    // The probe of a search step always lies inside the search interval.
    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> ((probe_cur >= lo_reg) && (probe_cur <= hi_reg)))
        else $error("probe outside the search interval");

endmodule
